FILE: src/search_position_hash_table_assert.svh
// Assertion macros used by the checker of the position hash table.
`ifndef SEARCH_POSITION_HASH_TABLE_ASSERT_SVH
`define SEARCH_POSITION_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spht assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spht assertion failed");

`endif

FILE: src/spht_pkg.sv
`default_nettype none

package spht_pkg;

  // Default table size: 2**SPHT_INDEX_BITS entries.
  localparam int SPHT_INDEX_BITS = 16;

  // Field widths.
  localparam int KEY_W   = 64;
  localparam int AGE_W   = 6;
  localparam int DEPTH_W = 7;
  localparam int ALU_W   = 18;

  // Item codes.
  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  // Bound flag codes.
  localparam logic [1:0] FLAG_EXACT = 2'd0;
  localparam logic [1:0] FLAG_UPPER = 2'd1;
  localparam logic [1:0] FLAG_LOWER = 2'd2;

  // Score and eval constants.
  localparam logic signed [ALU_W-1:0] MATE_BAND_POS = 18'sd29900;
  localparam logic signed [ALU_W-1:0] MATE_BAND_NEG = -18'sd29900;
  localparam logic [15:0] EVAL_NONE = 16'h8000;
  localparam logic [15:0] EVAL_MIN  = 16'h8001;

  // Configuration register byte address.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_AGE_ADDR = 2'd0;

  // Stream payload widths (whole bytes).
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 64;

  // One input item, key in the lowest bits.
  typedef struct packed {
    logic [15:0]      eval;
    logic [15:0]      new_move;
    logic [1:0]       bound_flag;
    logic [15:0]      score;
    logic [7:0]       ply;
    logic [15:0]      beta;
    logic [15:0]      alpha;
    logic [7:0]       depth;
    logic [KEY_W-1:0] key;
  } in_item_t;

  // One result item, hit in the lowest bit.
  typedef struct packed {
    logic [1:0]         hit_flag;
    logic [DEPTH_W-1:0] hit_depth;
    logic [15:0]        hit_eval;
    logic [15:0]        hit_move;
    logic [15:0]        hit_score;
    logic               cutoff;
    logic               hit;
  } out_item_t;

  // Stored entry payload, move in the lowest bits.
  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [1:0]         flag;
    logic [DEPTH_W-1:0] depth;
    logic [15:0]        eval;
    logic [15:0]        score;
    logic [15:0]        move;
  } entry_data_t;

  // Full table entry.
  typedef struct packed {
    entry_data_t      data;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Entry value after reset: key zero, all fields zero but the no-eval marker.
  localparam entry_t ENTRY_CLEAR = '{
    data: '{age: '0, flag: FLAG_EXACT, depth: '0, eval: EVAL_NONE, score: '0, move: '0},
    key:  '0
  };

  // Shared adder operation and its status.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage

`default_nettype wire

FILE: src/spht_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module spht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/spht_alu.sv
`default_nettype none

// Shared 18-bit signed add/subtract unit with sign and zero status.
module spht_alu
  import spht_pkg::*;
(
  input  wire alu_op_t                 op,
  input  wire logic signed [ALU_W-1:0] a,
  input  wire logic signed [ALU_W-1:0] b,
  output logic signed      [ALU_W-1:0] res,
  output alu_flags_t                   flags
);

  // Operands are sign- or zero-extended values of at most 16 bits, so no overflow occurs.
  always_comb begin
    case (op)
      ALU_SUB: res = a - b;
      ALU_ADD: res = a + b;
      default: res = a + b;
    endcase
    flags.neg  = res[ALU_W-1];
    flags.zero = (res == '0);
  end

endmodule

`default_nettype wire

FILE: src/search_position_hash_table.sv
`default_nettype none

// Direct-mapped position hash table with depth and age replacement. After reset the
// block sweeps the table once, one entry per cycle, and in_tready stays low until the
// sweep is done; configuration writes are taken throughout. After a store item the
// block returns to idle through the store state and gives no result. For a probe
// item the entry is read from the table RAM in the acceptance cycle, and then one
// 18-bit shared adder is used in five successive steps (two mate-band compares, the
// mate adjustment by ply, the depth compare and the alpha/beta compare) before the
// result is loaded into the output register. A new item may be accepted while that
// result still waits.
module search_position_hash_table
  import spht_pkg::*;
#(
  parameter int INDEX_BITS = SPHT_INDEX_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata, from bit 0: key, depth, alpha, beta, ply, score, bound_flag, new_move, eval
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: action
  input  wire logic                   in_tuser,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata, from bit 0: hit, cutoff, hit_score, hit_move, hit_eval, hit_depth, hit_flag
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Configuration port.
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DEPTH   = 1 << INDEX_BITS;
  localparam int ENTRY_W = $bits(entry_t);
  localparam int ITEM_W  = $bits(in_item_t);
  localparam int RES_W   = $bits(out_item_t);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_STORE,
    S_MHI,
    S_MLO,
    S_MADJ,
    S_DEPTH,
    S_BOUND
  } state_t;

  state_t                 state_r, state_nxt;
  logic [INDEX_BITS-1:0]  clr_cnt_r, clr_cnt_nxt;
  in_item_t               item_r, item_nxt;
  logic                   hit_r, hit_nxt;
  logic                   ge_hi_r, ge_hi_nxt;
  logic                   le_lo_r, le_lo_nxt;
  logic [15:0]            s_adj_r, s_adj_nxt;
  logic                   depth_ok_r, depth_ok_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [AGE_W-1:0]       age_r, age_nxt;

  in_item_t               in_item;
  logic                   in_acc;
  logic                   cfg_wr;
  entry_t                 ent;
  entry_t                 ent_rd;
  logic                   ram_we;
  logic [INDEX_BITS-1:0]  ram_waddr;
  entry_t                 ram_wdata;
  entry_t                 store_entry;
  logic                   store_we;
  logic                   key_eq;
  logic                   deeper;
  logic [15:0]            eval_sat;
  logic [DEPTH_W-1:0]     depth_clamp;
  logic                   flag_ok;
  logic                   out_free;

  alu_op_t                alu_op;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  alu_flags_t             alu_fl;

  logic signed [ALU_W-1:0] sdepth_x, rdepth_x, s_x, s_adj_x, ply_x, alpha_x, beta_x;

  assign in_item    = in_tdata[ITEM_W-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_data_r};
  assign out_free   = !out_valid_r || out_tready;

  // Configuration register access.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == CFG_AGE_ADDR);
  assign age_nxt    = cfg_wr ? cfg_pwdata[AGE_W-1:0] : age_r;
  assign cfg_prdata = (cfg_paddr == CFG_AGE_ADDR) ? {{(32-AGE_W){1'b0}}, age_r} : '0;

  // Table memory; the entry is read at the acceptance edge.
  spht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_item.key[INDEX_BITS-1:0]),
    .rdata (ent_rd)
  );

  assign ent = ent_rd;

  // Sign- and zero-extended operands for the shared adder.
  assign sdepth_x = {{(ALU_W-DEPTH_W){1'b0}}, ent.data.depth};
  assign rdepth_x = {{(ALU_W-8){item_r.depth[7]}}, item_r.depth};
  assign s_x      = {{(ALU_W-16){ent.data.score[15]}}, ent.data.score};
  assign s_adj_x  = {{(ALU_W-16){s_adj_r[15]}}, s_adj_r};
  assign ply_x    = {{(ALU_W-8){1'b0}}, item_r.ply};
  assign alpha_x  = {{(ALU_W-16){item_r.alpha[15]}}, item_r.alpha};
  assign beta_x   = {{(ALU_W-16){item_r.beta[15]}}, item_r.beta};

  // Operand selection per sequencer step.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = sdepth_x;
    alu_b  = rdepth_x;
    case (state_r)
      S_MHI: begin
        alu_a = s_x;
        alu_b = MATE_BAND_POS;
      end
      S_MLO: begin
        alu_a = s_x;
        alu_b = MATE_BAND_NEG;
      end
      S_MADJ: begin
        alu_a  = s_x;
        alu_op = ge_hi_r ? ALU_SUB : ALU_ADD;
        alu_b  = (ge_hi_r || le_lo_r) ? ply_x : '0;
      end
      S_BOUND: begin
        alu_a = s_adj_x;
        alu_b = (ent.data.flag == FLAG_UPPER) ? alpha_x : beta_x;
      end
      default: begin
        alu_a = sdepth_x;
        alu_b = rdepth_x;
      end
    endcase
  end

  spht_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_fl)
  );

  // Store decision: refresh a deeper same-key entry, keep a deeper current-age entry of another key, else replace.
  assign key_eq      = (ent.key == item_r.key);
  assign deeper      = !alu_fl.neg && !alu_fl.zero;
  assign eval_sat    = (item_r.eval == EVAL_NONE) ? EVAL_MIN : item_r.eval;
  assign depth_clamp = item_r.depth[7] ? '0 : item_r.depth[DEPTH_W-1:0];

  always_comb begin
    store_entry = ent;
    store_we    = 1'b0;
    if (state_r == S_STORE) begin
      if (key_eq && deeper) begin
        store_we                = 1'b1;
        store_entry.data.move   = (item_r.new_move != '0) ? item_r.new_move : ent.data.move;
        store_entry.data.eval   = eval_sat;
        store_entry.data.age    = age_r;
      end else if (!key_eq && (ent.data.age == age_r) && deeper) begin
        store_we = 1'b0;
      end else begin
        store_we                = 1'b1;
        store_entry.key         = item_r.key;
        store_entry.data.move   = item_r.new_move;
        store_entry.data.score  = item_r.score;
        store_entry.data.eval   = eval_sat;
        store_entry.data.depth  = depth_clamp;
        store_entry.data.flag   = item_r.bound_flag;
        store_entry.data.age    = age_r;
      end
    end
  end

  // Memory write port: clearing sweep or store.
  assign ram_we    = (state_r == S_CLR) || store_we;
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : item_r.key[INDEX_BITS-1:0];
  assign ram_wdata = (state_r == S_CLR) ? ENTRY_CLEAR : store_entry;

  // Bound check against the window.
  always_comb begin
    case (ent.data.flag)
      FLAG_EXACT: flag_ok = 1'b1;
      FLAG_UPPER: flag_ok = alu_fl.neg || alu_fl.zero;
      FLAG_LOWER: flag_ok = !alu_fl.neg;
      default:    flag_ok = 1'b0;
    endcase
  end

  // Sequencer next state and registered results.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = in_acc ? in_item : item_r;
    hit_nxt       = hit_r;
    ge_hi_nxt     = ge_hi_r;
    le_lo_nxt     = le_lo_r;
    s_adj_nxt     = s_adj_r;
    depth_ok_nxt  = depth_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == ACT_STORE) ? S_STORE : S_MHI;
        end
      end
      S_STORE: begin
        state_nxt = S_IDLE;
      end
      S_MHI: begin
        hit_nxt   = key_eq;
        ge_hi_nxt = !alu_fl.neg;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        le_lo_nxt = alu_fl.neg || alu_fl.zero;
        state_nxt = S_MADJ;
      end
      S_MADJ: begin
        s_adj_nxt = alu_res[15:0];
        state_nxt = S_DEPTH;
      end
      S_DEPTH: begin
        depth_ok_nxt = !alu_fl.neg;
        state_nxt    = S_BOUND;
      end
      S_BOUND: begin
        // Wait here while an earlier result is still held.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hit_r) begin
            out_data_nxt.hit       = 1'b1;
            out_data_nxt.cutoff    = depth_ok_r && flag_ok;
            out_data_nxt.hit_score = s_adj_r;
            out_data_nxt.hit_move  = ent.data.move;
            out_data_nxt.hit_eval  = ent.data.eval;
            out_data_nxt.hit_depth = ent.data.depth;
            out_data_nxt.hit_flag  = ent.data.flag;
          end else begin
            out_data_nxt.hit       = 1'b0;
            out_data_nxt.cutoff    = 1'b0;
            out_data_nxt.hit_score = '0;
            out_data_nxt.hit_move  = '0;
            out_data_nxt.hit_eval  = EVAL_NONE;
            out_data_nxt.hit_depth = '0;
            out_data_nxt.hit_flag  = FLAG_EXACT;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      age_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      age_r       <= age_nxt;
    end
    item_r     <= item_nxt;
    hit_r      <= hit_nxt;
    ge_hi_r    <= ge_hi_nxt;
    le_lo_r    <= le_lo_nxt;
    s_adj_r    <= s_adj_nxt;
    depth_ok_r <= depth_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: src/spht_checker.sv
`default_nettype none

`include "search_position_hash_table_assert.svh"

// Port-level checks of the position hash table.
module spht_checker
  import spht_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A held result keeps its value until taken.
  `SPHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))

  // One item at a time: the block is busy right after accepting one.
  `SPHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready)

  // A store accepted while no result is pending does not raise one.
  `SPHT_ASSERT_NEXT(a_store_silent, clk, rst_n,
                    in_acc && (in_tuser == ACT_STORE) && !out_tvalid, !out_tvalid)

  // A cutoff is only reported on a hit.
  `SPHT_ASSERT_NOW(a_cutoff_needs_hit, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0])

  // A miss reports no move and the no-eval marker.
  `SPHT_ASSERT_NOW(a_miss_fields, clk, rst_n, out_tvalid && !out_tdata[0],
                   (out_tdata[33:18] == 16'h0000) && (out_tdata[49:34] == EVAL_NONE))

endmodule

bind search_position_hash_table spht_checker u_spht_checker (.*);

`default_nettype wire
